// ===== hw/rtl/dlc_pkg.sv =====
// Shared codes, types and word tables for the directive line classifier.
package dlc_pkg;

    localparam int ChW    = 8;
    localparam int KindW  = 2;
    localparam int ClassW = 3;
    localparam int PhaseW = 4;
    localparam int PosW   = 3;

    localparam logic [PhaseW-1:0] PH_START = 4'd0;
    localparam logic [PhaseW-1:0] PH_LEAD  = 4'd1;
    localparam logic [PhaseW-1:0] PH_HASH  = 4'd2;
    localparam logic [PhaseW-1:0] PH_WORD  = 4'd3;
    localparam logic [PhaseW-1:0] PH_GAP1  = 4'd4;
    localparam logic [PhaseW-1:0] PH_NAME  = 4'd5;
    localparam logic [PhaseW-1:0] PH_GAP2  = 4'd6;
    localparam logic [PhaseW-1:0] PH_VALUE = 4'd7;
    localparam logic [PhaseW-1:0] PH_REST  = 4'd8;

    localparam logic [ClassW-1:0] CL_EMPTY   = 3'd0;
    localparam logic [ClassW-1:0] CL_NORMAL  = 3'd1;
    localparam logic [ClassW-1:0] CL_ERROR   = 3'd2;
    localparam logic [ClassW-1:0] CL_DEFINE  = 3'd3;
    localparam logic [ClassW-1:0] CL_UNDEF   = 3'd4;
    localparam logic [ClassW-1:0] CL_UNKNOWN = 3'd5;

    localparam logic [KindW-1:0] KIND_NAME  = 2'd0;
    localparam logic [KindW-1:0] KIND_VALUE = 2'd1;
    localparam logic [KindW-1:0] KIND_CLASS = 2'd2;

    localparam logic [ChW-1:0] CH_NL    = 8'h0A;
    localparam logic [ChW-1:0] CH_SPACE = 8'h20;
    localparam logic [ChW-1:0] CH_TAB   = 8'h09;
    localparam logic [ChW-1:0] CH_HASH  = 8'h23;

    localparam logic [PosW-1:0] POS_MAX = 3'd7;
    localparam logic [PosW-1:0] LEN_DEFINE = 3'd6;
    localparam logic [PosW-1:0] LEN_UNDEF  = 3'd5;

    // bit0: "define" still matches, bit1: "undef" still matches
    localparam logic [1:0] MATCH_ALL = 2'b11;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [PosW-1:0]   word_pos;
        logic [1:0]        match;
        logic [ClassW-1:0] pend;
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [KindW-1:0]  kind;
        logic [ChW-1:0]    out_byte;
        logic [ClassW-1:0] line_class;
    } t_result;

    localparam t_state STATE_RESET = '{phase: PH_START, word_pos: '0,
                                       match: MATCH_ALL, pend: CL_NORMAL};

    function automatic logic [ChW-1:0] define_char(input logic [PosW-1:0] pos);
        logic [ChW-1:0] c;
        unique case (pos)
            3'd0:    c = "d";
            3'd1:    c = "e";
            3'd2:    c = "f";
            3'd3:    c = "i";
            3'd4:    c = "n";
            3'd5:    c = "e";
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [ChW-1:0] undef_char(input logic [PosW-1:0] pos);
        logic [ChW-1:0] c;
        unique case (pos)
            3'd0:    c = "u";
            3'd1:    c = "n";
            3'd2:    c = "d";
            3'd3:    c = "e";
            3'd4:    c = "f";
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/dlc_step.sv =====
// Per-byte next-state and result logic of the line classifier.
module dlc_step
    import dlc_pkg::*;
(
    input  t_state         i_state,
    input  logic [ChW-1:0] i_ch,
    output t_state         o_state,
    output t_result        o_result
);

    logic              nl;
    logic              blank;
    logic              letter;
    logic [ClassW-1:0] word_cls;
    logic [1:0]        wb_match;
    logic [PosW-1:0]   wb_pos;
    logic [1:0]        hash_match;

    assign nl     = (i_ch == CH_NL);
    assign blank  = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
    assign letter = ((i_ch >= "A") && (i_ch <= "Z")) || ((i_ch >= "a") && (i_ch <= "z"));

    // word byte: narrow the candidates and advance the saturating position
    always_comb begin
        wb_match[0] = i_state.match[0] && (i_state.word_pos < LEN_DEFINE)
                      && (define_char(i_state.word_pos) == i_ch);
        wb_match[1] = i_state.match[1] && (i_state.word_pos < LEN_UNDEF)
                      && (undef_char(i_state.word_pos) == i_ch);
        wb_pos = (i_state.word_pos < POS_MAX) ? i_state.word_pos + 3'd1 : i_state.word_pos;
        hash_match[0] = (define_char('0) == i_ch);
        hash_match[1] = (undef_char('0) == i_ch);
    end

    always_comb begin
        priority if (i_state.match[0] && (i_state.word_pos == LEN_DEFINE)) begin
            word_cls = CL_DEFINE;
        end else if (i_state.match[1] && (i_state.word_pos == LEN_UNDEF)) begin
            word_cls = CL_UNDEF;
        end else begin
            word_cls = CL_UNKNOWN;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '{valid: 1'b0, kind: KIND_NAME, out_byte: '0, line_class: '0};
        if (nl) begin
            // end of line: report the class and start over
            o_state = STATE_RESET;
            o_result.valid = 1'b1;
            o_result.kind  = KIND_CLASS;
            unique case (i_state.phase)
                PH_START: o_result.line_class = CL_EMPTY;
                PH_LEAD:  o_result.line_class = CL_NORMAL;
                PH_HASH:  o_result.line_class = CL_ERROR;
                PH_WORD:  o_result.line_class = word_cls;
                default:  o_result.line_class = i_state.pend;
            endcase
        end else begin
            unique case (i_state.phase)
                PH_START, PH_LEAD: begin
                    priority if (blank) begin
                        o_state.phase = PH_LEAD;
                    end else if (i_ch == CH_HASH) begin
                        o_state.phase = PH_HASH;
                    end else begin
                        o_state.pend  = CL_NORMAL;
                        o_state.phase = PH_REST;
                    end
                end
                PH_HASH: begin
                    if (letter) begin
                        o_state.word_pos = 3'd1;
                        o_state.match    = hash_match;
                        o_state.phase    = PH_WORD;
                    end else begin
                        o_state.pend  = CL_ERROR;
                        o_state.phase = PH_REST;
                    end
                end
                PH_WORD: begin
                    if (blank) begin
                        o_state.pend  = word_cls;
                        o_state.phase = PH_GAP1;
                    end else begin
                        o_state.word_pos = wb_pos;
                        o_state.match    = wb_match;
                    end
                end
                PH_GAP1: begin
                    if (!blank) begin
                        o_state.phase     = PH_NAME;
                        o_result.valid    = 1'b1;
                        o_result.out_byte = i_ch;
                    end
                end
                PH_NAME: begin
                    if (blank) begin
                        o_state.phase = PH_GAP2;
                    end else begin
                        o_result.valid    = 1'b1;
                        o_result.out_byte = i_ch;
                    end
                end
                PH_GAP2: begin
                    if (!blank) begin
                        if (i_state.pend == CL_DEFINE) begin
                            o_state.phase     = PH_VALUE;
                            o_result.valid    = 1'b1;
                            o_result.kind     = KIND_VALUE;
                            o_result.out_byte = i_ch;
                        end else begin
                            o_state.phase = PH_REST;
                        end
                    end
                end
                PH_VALUE: begin
                    o_result.valid    = 1'b1;
                    o_result.kind     = KIND_VALUE;
                    o_result.out_byte = i_ch;
                end
                default: begin
                    // skip to end of line
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/directive_line_classifier_top.sv =====
// Top level of the directive line classifier: state and result registers.
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_ready    i_ch
//  output   out        o_valid / i_ready    o_kind, o_out_byte, o_line_class
//
// One byte per cycle while not stalled: the line state updates in the cycle a
// request is taken, and its result (if any) shows on the output register the
// next cycle. Sync active-low reset returns to line start and drops any held
// result. A held result blocks input only while the consumer stalls; a request
// is taken in the same cycle the held result drains.
module directive_line_classifier_top
    import dlc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ChW-1:0]    i_ch,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [KindW-1:0]  o_kind,
    output logic [ChW-1:0]    o_out_byte,
    output logic [ClassW-1:0] o_line_class
);

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    r_out_valid;
    logic [KindW-1:0]  r_kind;
    logic [ChW-1:0]    r_out_byte;
    logic [ClassW-1:0] r_line_class;
    logic    accept;

    dlc_step u_step (
        .i_state  (r_state),
        .i_ch     (i_ch),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_state     <= n_state;
            r_out_valid <= n_result.valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind       <= n_result.kind;
            r_out_byte   <= n_result.out_byte;
            r_line_class <= n_result.line_class;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_out_byte;
    assign o_line_class = r_line_class;

    a_nl_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_ch == CH_NL) |=> (r_state.phase == PH_START)
            && (r_state.word_pos == '0) && (r_state.match == MATCH_ALL)
            && o_valid && (o_kind == KIND_CLASS))
        else $error("newline did not restart the line");

    a_class_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_CLASS) |-> (o_out_byte == '0))
        else $error("class report carries a byte");

    a_byte_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_CLASS) |-> (o_line_class == '0))
        else $error("byte result carries a class");

    a_value_define: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_VALUE) |-> (r_state.pend == CL_DEFINE)
            && (r_state.phase == PH_VALUE))
        else $error("value byte outside a define line");

endmodule

// ===== tb/directive_line_classifier_top_tb.sv =====
// Self-checking testbench for directive_line_classifier_top with a line-level predictor.
module directive_line_classifier_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlc_pkg::*;

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [ChW-1:0]    data;
        logic [ClassW-1:0] cls;
    } t_token;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [ChW-1:0]    i_ch;
    logic              o_valid;
    logic              i_ready;
    logic [KindW-1:0]  o_kind;
    logic [ChW-1:0]    o_out_byte;
    logic [ClassW-1:0] o_line_class;

    // line state of the predictor
    logic [PhaseW-1:0] ln_phase;
    logic [PosW-1:0]   ln_word_len;
    logic [1:0]        ln_match;     // bit0 define, bit1 undef
    logic [ClassW-1:0] ln_class;

    t_token         expected_tokens[$];
    logic [ChW-1:0] line_buf[$];
    int             fail_count = 0;
    int             bytes_sent = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    bit             quiet = 1'b0;

    string define_word = "define";
    string undef_word  = "undef";
    string near_miss[10] = '{"defin", "definee", "undeff", "unde", "Define", "UNDEF", "d",
                             "u", "defineXY", "undefined"};

    directive_line_classifier_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_ch         (i_ch),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_line_class (o_line_class)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic bit is_blank(input logic [ChW-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_alpha(input logic [ChW-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void reset_line_state();
        ln_phase    = PH_START;
        ln_word_len = '0;
        ln_match    = 2'b11;
        ln_class    = CL_NORMAL;
    endfunction

    function automatic void push_token(input logic [KindW-1:0] k, input logic [ChW-1:0] d,
                                       input logic [ClassW-1:0] cls);
        t_token t;
        t.kind = k;
        t.data = d;
        t.cls  = cls;
        expected_tokens.push_back(t);
    endfunction

    function automatic void close_line(input logic [ClassW-1:0] cls);
        reset_line_state();
        push_token(KIND_CLASS, '0, cls);
    endfunction

    function automatic void track_word(input logic [ChW-1:0] c);
        logic [1:0] m;
        m = ln_match;
        if (!(ln_word_len < 3'd6 && ChW'(define_word[ln_word_len]) == c))
            m &= 2'b10;
        if (!(ln_word_len < 3'd5 && ChW'(undef_word[ln_word_len]) == c))
            m &= 2'b01;
        ln_match = m;
        if (ln_word_len < 3'd7)
            ln_word_len++;
    endfunction

    function automatic logic [ClassW-1:0] word_verdict();
        if (ln_match[0] && ln_word_len == 3'd6)
            return CL_DEFINE;
        if (ln_match[1] && ln_word_len == 3'd5)
            return CL_UNDEF;
        return CL_UNKNOWN;
    endfunction

    function automatic void classify_byte(input logic [ChW-1:0] c);
        bit nl;
        bit bl;
        nl = (c == CH_NL);
        bl = is_blank(c);
        case (ln_phase)
            PH_START, PH_LEAD: begin
                if (nl)
                    close_line(ln_phase == PH_START ? CL_EMPTY : CL_NORMAL);
                else if (bl)
                    ln_phase = PH_LEAD;
                else if (c == CH_HASH)
                    ln_phase = PH_HASH;
                else begin
                    ln_class = CL_NORMAL;
                    ln_phase = PH_REST;
                end
            end
            PH_HASH: begin
                if (nl)
                    close_line(CL_ERROR);
                else if (is_alpha(c)) begin
                    ln_word_len = '0;
                    ln_match    = 2'b11;
                    track_word(c);
                    ln_phase = PH_WORD;
                end else begin
                    ln_class = CL_ERROR;
                    ln_phase = PH_REST;
                end
            end
            PH_WORD: begin
                if (nl)
                    close_line(word_verdict());
                else if (bl) begin
                    ln_class = word_verdict();
                    ln_phase = PH_GAP1;
                end else
                    track_word(c);
            end
            PH_GAP1: begin
                if (nl)
                    close_line(ln_class);
                else if (!bl) begin
                    ln_phase = PH_NAME;
                    push_token(KIND_NAME, c, '0);
                end
            end
            PH_NAME: begin
                if (nl)
                    close_line(ln_class);
                else if (bl)
                    ln_phase = PH_GAP2;
                else
                    push_token(KIND_NAME, c, '0);
            end
            PH_GAP2: begin
                if (nl)
                    close_line(ln_class);
                else if (!bl) begin
                    if (ln_class == CL_DEFINE) begin
                        ln_phase = PH_VALUE;
                        push_token(KIND_VALUE, c, '0);
                    end else
                        ln_phase = PH_REST;
                end
            end
            PH_VALUE: begin
                if (nl)
                    close_line(ln_class);
                else
                    push_token(KIND_VALUE, c, '0);
            end
            default: begin
                if (nl)
                    close_line(ln_class);
            end
        endcase
    endfunction

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: kind %0d byte %02h class %0d",
                             o_kind, o_out_byte, o_line_class);
            end else begin
                want = expected_tokens.pop_front();
                if (o_kind !== want.kind || o_out_byte !== want.data ||
                    o_line_class !== want.cls) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected kind %0d byte %02h class %0d, ",
                                  "got kind %0d byte %02h class %0d"},
                                 want.kind, want.data, want.cls,
                                 o_kind, o_out_byte, o_line_class);
                end
            end
        end
    end

    // consumer side: random stall bursts
    initial begin
        int stall;
        i_ready = 1'b0;
        stall   = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
                i_ready <= 1'b0;
                stall = $urandom_range(1, 17) - 1;
            end else
                i_ready <= 1'b1;
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_byte(input logic [ChW-1:0] c);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 17);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_ch    <= c;
        do @(posedge i_clk); while (!o_ready);
        classify_byte(c);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(ChW'(s[k]));
    endfunction

    function automatic logic [ChW-1:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return r < 26 ? ChW'(8'h41 + r) : ChW'(8'h61 + r - 26);
    endfunction

    function automatic logic [ChW-1:0] rand_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [ChW-1:0] rand_name_byte();
        logic [ChW-1:0] c;
        do c = ChW'($urandom_range(0, 255)); while (c == CH_NL || is_blank(c));
        return c;
    endfunction

    // send the buffered line; a broken line is cut short at a random point
    task automatic send_line(input bit broken);
        int keep;
        if (broken) begin
            keep = $urandom_range(0, line_buf.size());
            while (line_buf.size() > keep)
                void'(line_buf.pop_back());
        end
        line_buf.push_back(CH_NL);
        while (line_buf.size() != 0)
            send_byte(line_buf.pop_front());
    endtask

    function automatic void build_directive_line();
        int n;
        repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
        line_buf.push_back(CH_HASH);
        case ($urandom_range(0, 9))
            0, 1, 2: add_text("define");
            3, 4, 5: add_text("undef");
            6:       add_text(near_miss[$urandom_range(0, 9)]);
            7, 8: begin
                n = $urandom_range(1, 9);
                repeat (n) line_buf.push_back(rand_letter());
            end
            default: begin
                // first byte just outside the letter ranges
                case ($urandom_range(0, 3))
                    0:       line_buf.push_back(8'h40);
                    1:       line_buf.push_back(8'h5B);
                    2:       line_buf.push_back(8'h60);
                    default: line_buf.push_back(8'h7B);
                endcase
                line_buf.push_back(rand_letter());
            end
        endcase
        repeat ($urandom_range(1, 3)) line_buf.push_back(rand_blank());
        repeat ($urandom_range(1, 6)) line_buf.push_back(rand_name_byte());
        if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(rand_blank());
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0)
                    line_buf.push_back(rand_blank());
                else
                    line_buf.push_back(rand_name_byte());
            end
        end
    endfunction

    function automatic void build_noise_line();
        repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 7))
                0, 1:    line_buf.push_back(ChW'($urandom_range(0, 255)));
                2, 7:    line_buf.push_back(rand_blank());
                3:       line_buf.push_back(CH_HASH);
                4, 5:    add_text(near_miss[$urandom_range(0, 9)]);
                default: line_buf.push_back(rand_letter());
            endcase
        end
    endfunction

    task automatic mixed_lines(input int target);
        while (bytes_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
                build_directive_line();
                send_line($urandom_range(0, 4) == 0);
            end else begin
                build_noise_line();
                send_line(1'b0);
            end
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_text("\n");                 // empty line
        add_text(" \t\n");              // blanks only
        add_text("#\n");                // newline right after hash
        line_buf.push_back(CH_HASH);    // non-letter after hash, top byte value
        line_buf.push_back(8'hFF);
        line_buf.push_back(CH_NL);
        line_buf.push_back(8'h00);      // normal line, bottom byte value
        line_buf.push_back(CH_NL);
        add_text("#define a b\n");
        add_text("#undef Z\n");         // newline ends the name
        while (line_buf.size() != 0)
            send_byte(line_buf.pop_front());
        wait_drained();
    endtask

    task automatic test_directive_lines();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        mixed_lines(bytes_sent + 650);
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        mixed_lines(bytes_sent + 40);
        wait_drained();
        mixed_lines(bytes_sent + 30);
    endtask

    task automatic test_noise_lines();
        send_idle_pct = 35;
        recv_idle_pct = 35;
        while (bytes_sent < 930) begin
            build_noise_line();
            send_line(1'b0);
        end
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        mixed_lines(bytes_sent + 220);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ch    = '0;
        reset_line_state();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_directive_lines();
        test_sender_pause();
        test_noise_lines();
        test_full_rate();

        @(negedge i_clk);
        i_valid <= 1'b0;
        for (int k = 0; k < 2000 && expected_tokens.size() != 0; k++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_tokens.size() != 0) begin
            fail_count += expected_tokens.size();
            $display("%0d expected results never arrived", expected_tokens.size());
        end
        if (fail_count == 0)
            $display("PASS directive_line_classifier_top");
        else
            $display("FAIL directive_line_classifier_top");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("FAIL directive_line_classifier_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dlc_pkg.sv
hw/rtl/dlc_step.sv
hw/rtl/directive_line_classifier_top.sv
tb/directive_line_classifier_top_tb.sv
